>>> design/agot_pkg.sv
// Shared widths, register indexes, effect codes and helpers for the audio effect block.
`default_nettype none

package agot_pkg;

  // Field widths
  localparam int SMP_W  = 16;
  localparam int MODE_W = 2;
  localparam int GAIN_W = 12;
  localparam int OFS_W  = 16;
  localparam int AMP_W  = 15;
  localparam int TONE_W = 24;
  localparam int RATE_W = 18;
  localparam int CIDX_W = 3;
  localparam int CDAT_W = 24;

  // Shared multiplier: signed operands, registered product
  localparam int MUL_W  = 25;
  localparam int PROD_W = 2 * MUL_W;

  // Result accumulator, wide enough for sample*32768 + amplitude*sine
  localparam int ACC_W = 34;

  // Phase divider: tone*position over rate*256
  localparam int DVD_W = TONE_W + RATE_W;
  localparam int DVS_W = RATE_W + 8;

  // Quarter-wave polynomial, Q15 (x up to 1.0 needs 17 bits)
  localparam int QX_W = 17;
  localparam logic [QX_W-1:0] POLY_C1 = 17'd51472;
  localparam logic [QX_W-1:0] POLY_C3 = 17'd21167;
  localparam logic [QX_W-1:0] POLY_C5 = 17'd2611;
  localparam logic [QX_W-1:0] Q15_ONE = 17'd32768;
  localparam logic [QX_W-1:0] MAG_MAX = 17'd32767;

  typedef logic [CIDX_W-1:0] reg_idx_t;

  localparam reg_idx_t REG_EFFECT_MODE  = 3'd0;
  localparam reg_idx_t REG_GAIN_Q8      = 3'd1;
  localparam reg_idx_t REG_OFFSET_VALUE = 3'd2;
  localparam reg_idx_t REG_TREMOLO_AMP  = 3'd3;
  localparam reg_idx_t REG_TONE_FREQ_Q8 = 3'd4;
  localparam reg_idx_t REG_SAMPLE_RATE  = 3'd5;

  typedef enum logic [MODE_W-1:0] {
    MODE_GAIN    = 2'd0,
    MODE_OFFSET  = 2'd1,
    MODE_TREMOLO = 2'd2,
    MODE_BYPASS  = 2'd3
  } mode_t;

  localparam logic signed [ACC_W-1:0] SAT_HI = 34'sd32767;
  localparam logic signed [ACC_W-1:0] SAT_LO = -34'sd32768;

  // Clamp a wide signed value to the 16-bit sample range
  function automatic logic signed [SMP_W-1:0] sat16(input logic signed [ACC_W-1:0] v);
    logic signed [SMP_W-1:0] r;
    if (v > SAT_HI) begin
      r = 16'sh7fff;
    end else if (v < SAT_LO) begin
      r = 16'sh8000;
    end else begin
      r = v[SMP_W-1:0];
    end
    return r;
  endfunction

endpackage

`default_nettype wire

>>> design/agot_mul.sv
// Shared signed multiplier with a registered product.
`default_nettype none

module agot_mul (
  input  wire logic                                  clk,
  input  wire logic                                  mul_en,
  input  wire logic signed [agot_pkg::MUL_W-1:0]     mul_a,
  input  wire logic signed [agot_pkg::MUL_W-1:0]     mul_b,
  output logic signed [agot_pkg::PROD_W-1:0]         prod
);

  logic signed [agot_pkg::PROD_W-1:0] prod_r;

  // Hold the product while the enable is low
  always_ff @(posedge clk) begin
    if (mul_en) begin
      prod_r <= mul_a * mul_b;
    end
  end

  assign prod = prod_r;

endmodule

`default_nettype wire

>>> design/agot_div.sv
// Restoring divider, two quotient bits per cycle; keeps the low quotient bits.
`default_nettype none

module agot_div #(
  parameter int DVD_W = 42,
  parameter int DVS_W = 26,
  parameter int QUO_W = 8
) (
  input  wire logic             clk,
  input  wire logic             rst_n,
  input  wire logic             load,
  input  wire logic [DVD_W-1:0] dividend,
  input  wire logic [DVS_W-1:0] divisor,
  output logic                  done,
  output logic [QUO_W-1:0]      quotient
);

  // dividend is followed by QUO_W zero bits; pad to an even bit count
  localparam int TOT_W = DVD_W + QUO_W;
  localparam int NB    = TOT_W + (TOT_W % 2);
  localparam int STEPS = NB / 2;
  localparam int CNT_W = $clog2(STEPS + 1);

  logic [NB-1:0]    dvd_r;
  logic [DVS_W-1:0] rem_r;
  logic [DVS_W-1:0] dvs_r;
  logic [QUO_W-1:0] quo_r;
  logic [CNT_W-1:0] cnt_r;
  logic             busy_r;
  logic             done_r;

  logic [DVS_W:0]   r1, r2;
  logic             q1, q2;
  logic [DVS_W-1:0] m1, m2;

  always_comb begin
    r1 = {rem_r, dvd_r[NB-1]};
    q1 = (r1 >= {1'b0, dvs_r});
    m1 = q1 ? DVS_W'(r1 - {1'b0, dvs_r}) : r1[DVS_W-1:0];
    r2 = {m1, dvd_r[NB-2]};
    q2 = (r2 >= {1'b0, dvs_r});
    m2 = q2 ? DVS_W'(r2 - {1'b0, dvs_r}) : r2[DVS_W-1:0];
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      done_r <= 1'b0;
      if (load) begin
        busy_r <= 1'b1;
        cnt_r  <= CNT_W'(STEPS);
      end else if (busy_r) begin
        cnt_r <= cnt_r - CNT_W'(1);
        if (cnt_r == CNT_W'(1)) begin
          busy_r <= 1'b0;
          done_r <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      dvd_r <= NB'({dividend, QUO_W'(0)});
      rem_r <= '0;
      dvs_r <= divisor;
      quo_r <= '0;
    end else if (busy_r) begin
      dvd_r <= dvd_r << 2;
      rem_r <= m2;
      quo_r <= {quo_r[QUO_W-3:0], q1, q2};
    end
  end

  assign done     = done_r;
  assign quotient = quo_r;

endmodule

`default_nettype wire

>>> design/audio_gain_offset_tremolo.sv
// Top level: per-sample gain, offset, sine tremolo or bypass on interleaved stereo PCM.
//
//  channel | direction | ports                                   | handshake
//  --------+-----------+-----------------------------------------+----------------------
//  in      | to block  | in_sample, in_first_sample              | in_valid / in_ready
//  out     | from block| out_processed_sample                    | out_valid / out_ready
//  cfg     | to block  | cfg_index, cfg_data                     | cfg_valid / cfg_ready
//
// One item is in work at a time. Offset and pass-through items go straight to the final step,
// gain items through the gain multiply step, tremolo items through the phase divider, which
// retires two quotient bits a cycle, and six multiplier passes.
// Reset (synchronous, rst_n low) restores the register defaults, clears parity and position.
// in_ready is high only in idle; the next item is taken while a result waits in the output
// register, and a finished item holds in its last step, product frozen, until it drains.
`default_nettype none

module audio_gain_offset_tremolo #(
  // Must be a power of two, 64 to 4096
  parameter int SINE_TABLE_SIZE = 256
) (
  input  wire logic                                  clk,
  input  wire logic                                  rst_n,
  // input items
  input  wire logic                                  in_valid,
  output logic                                       in_ready,
  input  wire logic signed [agot_pkg::SMP_W-1:0]     in_sample,
  input  wire logic                                  in_first_sample,
  // result items
  output logic                                       out_valid,
  input  wire logic                                  out_ready,
  output logic signed [agot_pkg::SMP_W-1:0]          out_processed_sample,
  // register writes
  input  wire logic                                  cfg_valid,
  output logic                                       cfg_ready,
  input  wire logic [agot_pkg::CIDX_W-1:0]           cfg_index,
  input  wire logic [agot_pkg::CDAT_W-1:0]           cfg_data
);

  localparam int SIZE_LG = $clog2(SINE_TABLE_SIZE);
  // x = low index bits scaled into Q15 quarter-wave phase
  localparam int XPAD    = 17 - SIZE_LG;

  typedef enum logic [10:0] {
    S_IDLE  = 11'b00000000001,
    S_GAIN  = 11'b00000000010,
    S_TPOS  = 11'b00000000100,
    S_DLOAD = 11'b00000001000,
    S_DIV   = 11'b00000010000,
    S_SQ    = 11'b00000100000,
    S_P1    = 11'b00001000000,
    S_P2    = 11'b00010000000,
    S_P3    = 11'b00100000000,
    S_AMP   = 11'b01000000000,
    S_FIN   = 11'b10000000000
  } state_t;

  // ---------------------------------------------------------------------------
  // Configuration registers; writes are always taken
  // ---------------------------------------------------------------------------
  agot_pkg::mode_t                 mode_r;
  logic [agot_pkg::GAIN_W-1:0]     gain_r;
  logic [agot_pkg::OFS_W-1:0]      ofs_r;
  logic [agot_pkg::AMP_W-1:0]      amp_r;
  logic [agot_pkg::TONE_W-1:0]     tone_r;
  logic [agot_pkg::RATE_W-1:0]     rate_r;

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      mode_r <= agot_pkg::MODE_GAIN;
      gain_r <= 12'd256;
      ofs_r  <= '0;
      amp_r  <= '0;
      tone_r <= 24'd256;
      rate_r <= 18'd44100;
    end else if (cfg_valid) begin
      case (cfg_index)
        agot_pkg::REG_EFFECT_MODE:  mode_r <= agot_pkg::mode_t'(cfg_data[agot_pkg::MODE_W-1:0]);
        agot_pkg::REG_GAIN_Q8:      gain_r <= cfg_data[agot_pkg::GAIN_W-1:0];
        agot_pkg::REG_OFFSET_VALUE: ofs_r  <= cfg_data[agot_pkg::OFS_W-1:0];
        agot_pkg::REG_TREMOLO_AMP:  amp_r  <= cfg_data[agot_pkg::AMP_W-1:0];
        agot_pkg::REG_TONE_FREQ_Q8: tone_r <= cfg_data[agot_pkg::TONE_W-1:0];
        agot_pkg::REG_SAMPLE_RATE:  rate_r <= cfg_data[agot_pkg::RATE_W-1:0];
        default: ;
      endcase
    end
  end

  // A zero rate behaves as one frame per second
  logic [agot_pkg::RATE_W-1:0] rate_eff;
  assign rate_eff = (rate_r == '0) ? agot_pkg::RATE_W'(1) : rate_r;

  // ---------------------------------------------------------------------------
  // Sequencer state and per-item registers
  // ---------------------------------------------------------------------------
  state_t state_r, state_nxt;

  logic                                in_fire;
  logic signed [agot_pkg::SMP_W-1:0]   smp_r;
  logic [agot_pkg::RATE_W-1:0]         pos_use_r;
  logic [agot_pkg::RATE_W-1:0]         pos_r, pos_nxt;
  logic                                parity_r, parity_nxt;
  logic [agot_pkg::QX_W-1:0]           x_r;
  logic [agot_pkg::QX_W-1:0]           x2_r;
  logic                                neg_r;

  logic                                out_valid_r, out_valid_nxt;
  logic signed [agot_pkg::SMP_W-1:0]   out_data_r;
  logic                                out_load;

  assign in_ready = (state_r == S_IDLE);
  assign in_fire  = in_valid && in_ready;

  // Frame position: restart on first_sample, advance after the second channel
  logic [agot_pkg::RATE_W-1:0] pos_base;
  logic                        parity_base;
  logic [agot_pkg::RATE_W:0]   pos_inc;

  always_comb begin
    pos_base    = in_first_sample ? '0 : pos_r;
    parity_base = in_first_sample ? 1'b0 : parity_r;
    pos_inc     = {1'b0, pos_base} + (agot_pkg::RATE_W + 1)'(1);
    pos_nxt     = pos_r;
    parity_nxt  = parity_r;
    if (in_fire) begin
      parity_nxt = ~parity_base;
      if (parity_base) begin
        pos_nxt = (pos_inc >= {1'b0, rate_eff}) ? '0 : pos_inc[agot_pkg::RATE_W-1:0];
      end else begin
        pos_nxt = pos_base;
      end
    end
  end

  // ---------------------------------------------------------------------------
  // Shared multiplier and phase divider
  // ---------------------------------------------------------------------------
  logic signed [agot_pkg::MUL_W-1:0]   mul_a, mul_b;
  logic signed [agot_pkg::PROD_W-1:0]  prod;
  logic                                mul_en;
  logic [agot_pkg::QX_W-1:0]           prod_sh;
  logic [agot_pkg::QX_W-1:0]           poly_t;
  logic [agot_pkg::QX_W-1:0]           sin_mag;
  logic signed [agot_pkg::QX_W-1:0]    sin_val;

  logic                                div_load;
  logic                                div_done;
  logic [SIZE_LG-1:0]                  div_quo;

  // Q15 product realigned back to Q15
  assign prod_sh = prod[31:15];

  // Freeze the product while a finished item waits for the output register
  assign mul_en = (state_r != S_FIN);

  agot_mul u_mul (
    .clk    (clk),
    .mul_en (mul_en),
    .mul_a  (mul_a),
    .mul_b  (mul_b),
    .prod   (prod)
  );

  assign div_load = (state_r == S_DLOAD);

  agot_div #(
    .DVD_W (agot_pkg::DVD_W),
    .DVS_W (agot_pkg::DVS_W),
    .QUO_W (SIZE_LG)
  ) u_div (
    .clk      (clk),
    .rst_n    (rst_n),
    .load     (div_load),
    .dividend (prod[agot_pkg::DVD_W-1:0]),
    .divisor  ({rate_eff, 8'd0}),
    .done     (div_done),
    .quotient (div_quo)
  );

  // Operand select: the polynomial and amplitude steps feed the multiplier from the previous product
  always_comb begin
    mul_a   = '0;
    mul_b   = '0;
    poly_t  = '0;
    sin_mag = (prod_sh > agot_pkg::MAG_MAX) ? agot_pkg::MAG_MAX : prod_sh;
    sin_val = neg_r ? $signed(agot_pkg::QX_W'(0) - sin_mag) : $signed(sin_mag);
    case (state_r)
      S_GAIN: begin
        mul_a = {{(agot_pkg::MUL_W - agot_pkg::SMP_W){smp_r[agot_pkg::SMP_W-1]}}, smp_r};
        mul_b = agot_pkg::MUL_W'(gain_r);
      end
      S_TPOS: begin
        mul_a = agot_pkg::MUL_W'(tone_r);
        mul_b = agot_pkg::MUL_W'(pos_use_r);
      end
      S_SQ: begin
        mul_a = agot_pkg::MUL_W'(x_r);
        mul_b = agot_pkg::MUL_W'(x_r);
      end
      S_P1: begin
        mul_a = agot_pkg::MUL_W'(agot_pkg::POLY_C5);
        mul_b = agot_pkg::MUL_W'(prod_sh);
      end
      S_P2: begin
        poly_t = agot_pkg::POLY_C3 - prod_sh;
        mul_a  = agot_pkg::MUL_W'(poly_t);
        mul_b  = agot_pkg::MUL_W'(x2_r);
      end
      S_P3: begin
        poly_t = agot_pkg::POLY_C1 - prod_sh;
        mul_a  = agot_pkg::MUL_W'(poly_t);
        mul_b  = agot_pkg::MUL_W'(x_r);
      end
      S_AMP: begin
        mul_a = {{(agot_pkg::MUL_W - agot_pkg::QX_W){sin_val[agot_pkg::QX_W-1]}}, sin_val};
        mul_b = agot_pkg::MUL_W'(amp_r);
      end
      default: ;
    endcase
  end

  // ---------------------------------------------------------------------------
  // Result: truncate toward zero, saturate
  // ---------------------------------------------------------------------------
  localparam logic signed [agot_pkg::ACC_W-1:0] ADJ_8  = 34'sd255;
  localparam logic signed [agot_pkg::ACC_W-1:0] ADJ_15 = 34'sd32767;

  logic signed [agot_pkg::ACC_W-1:0] prod_lo, smp_ext, ofs_ext;
  logic signed [agot_pkg::ACC_W-1:0] gain_adj, gain_q, sum_o, trem_tot, trem_adj, trem_q;
  logic signed [agot_pkg::SMP_W-1:0] res;

  always_comb begin
    prod_lo  = prod[agot_pkg::ACC_W-1:0];
    smp_ext  = {{(agot_pkg::ACC_W - agot_pkg::SMP_W){smp_r[agot_pkg::SMP_W-1]}}, smp_r};
    ofs_ext  = {{(agot_pkg::ACC_W - agot_pkg::OFS_W){1'b0}}, ofs_r};
    gain_adj = prod_lo + (prod_lo[agot_pkg::ACC_W-1] ? ADJ_8 : '0);
    gain_q   = gain_adj >>> 8;
    sum_o    = smp_ext + ofs_ext;
    trem_tot = (smp_ext <<< 15) + prod_lo;
    trem_adj = trem_tot + (trem_tot[agot_pkg::ACC_W-1] ? ADJ_15 : '0);
    trem_q   = trem_adj >>> 15;
    case (mode_r)
      agot_pkg::MODE_GAIN:    res = agot_pkg::sat16(gain_q);
      agot_pkg::MODE_OFFSET:  res = agot_pkg::sat16(sum_o);
      agot_pkg::MODE_TREMOLO: res = agot_pkg::sat16(trem_q);
      default:                res = smp_r;
    endcase
  end

  // Load the output register when it is empty or being drained
  assign out_load = (state_r == S_FIN) && (!out_valid_r || out_ready);

  always_comb begin
    out_valid_nxt = out_valid_r;
    if (out_load) begin
      out_valid_nxt = 1'b1;
    end else if (out_ready) begin
      out_valid_nxt = 1'b0;
    end
  end

  // ---------------------------------------------------------------------------
  // Next state
  // ---------------------------------------------------------------------------
  always_comb begin
    state_nxt = state_r;
    case (state_r)
      S_IDLE: begin
        if (in_fire) begin
          case (mode_r)
            agot_pkg::MODE_GAIN:    state_nxt = S_GAIN;
            agot_pkg::MODE_TREMOLO: state_nxt = S_TPOS;
            default:                state_nxt = S_FIN;
          endcase
        end
      end
      S_GAIN:  state_nxt = S_FIN;
      S_TPOS:  state_nxt = S_DLOAD;
      S_DLOAD: state_nxt = S_DIV;
      S_DIV: begin
        if (div_done) begin
          state_nxt = S_SQ;
        end
      end
      S_SQ:  state_nxt = S_P1;
      S_P1:  state_nxt = S_P2;
      S_P2:  state_nxt = S_P3;
      S_P3:  state_nxt = S_AMP;
      S_AMP: state_nxt = S_FIN;
      S_FIN: begin
        if (out_load) begin
          state_nxt = S_IDLE;
        end
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  // ---------------------------------------------------------------------------
  // Registers
  // ---------------------------------------------------------------------------
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      pos_r       <= '0;
      parity_r    <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      pos_r       <= pos_nxt;
      parity_r    <= parity_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  // Phase index from the divider: top two bits pick the quadrant
  logic [14:0] x_raw;
  assign x_raw = {div_quo[SIZE_LG-3:0], XPAD'(0)};

  always_ff @(posedge clk) begin
    if (in_fire) begin
      smp_r     <= in_sample;
      pos_use_r <= pos_base;
    end
    if ((state_r == S_DIV) && div_done) begin
      x_r   <= div_quo[SIZE_LG-2] ? (agot_pkg::Q15_ONE - {2'b00, x_raw}) : {2'b00, x_raw};
      neg_r <= div_quo[SIZE_LG-1];
    end
    // hold x^2 for the second polynomial step
    if (state_r == S_P1) begin
      x2_r <= prod_sh;
    end
    if (out_load) begin
      out_data_r <= res;
    end
  end

  assign out_valid            = out_valid_r;
  assign out_processed_sample = out_data_r;

endmodule

`default_nettype wire
